@@ design/rtc_time_to_seconds_uptime_defines.svh @@
// Assertion macros shared by the RTC snapshot converter RTL.
`ifndef RTC_TIME_TO_SECONDS_UPTIME_DEFINES_SVH
`define RTC_TIME_TO_SECONDS_UPTIME_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTCTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rtcts_pkg.sv @@
// Shared types and constants for the RTC snapshot to seconds converter.
package rtcts_pkg;

    // Calendar base of the seconds count
    localparam int unsigned BASE_YEAR = 2000;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_BINARY_MODE  = 1'b0,
        REG_HOUR_24_MODE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic binary_mode;
        logic hour_24_mode;
    } cfg_t;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 120;

    // Exact constant-reciprocal division.
    // Days: (x >> 7) / 675 with a 26-bit reciprocal scaled by 2^35.
    localparam int unsigned DAY_PRE_SHIFT   = 7;
    localparam int unsigned DAY_RECIP_SHIFT = 35;
    localparam longint unsigned DAY_RECIP =
        ((64'd1 << DAY_RECIP_SHIFT) + 64'd674) / 64'd675;
    // Hours: remainder below one day, reciprocal scaled by 2^32.
    localparam int unsigned HOUR_RECIP_SHIFT = 32;
    localparam longint unsigned HOUR_RECIP =
        ((64'd1 << HOUR_RECIP_SHIFT) + 64'd3599) / 64'd3600;
    // Minutes: remainder below one hour, reciprocal scaled by 2^20.
    localparam int unsigned MIN_RECIP_SHIFT = 20;
    localparam longint unsigned MIN_RECIP =
        ((64'd1 << MIN_RECIP_SHIFT) + 64'd59) / 64'd60;

endpackage

@@ design/rtcts_apb_regs.sv @@
// APB configuration registers: binary mode and 24-hour mode.
`include "rtc_time_to_seconds_uptime_defines.svh"

module rtcts_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtcts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rtcts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rtcts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output rtcts_pkg::cfg_t                   cfg
);
    import rtcts_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1]);
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_BINARY_MODE:  cfg_next.binary_mode  = pwdata[0];
                REG_HOUR_24_MODE: cfg_next.hour_24_mode = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.binary_mode  <= 1'b0;
            cfg_reg.hour_24_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_BINARY_MODE:  prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.binary_mode};
            REG_HOUR_24_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.hour_24_mode};
            default:          prdata = '0;
        endcase
    end

    `RTCTS_ASSERT_NEXT(a_bin_write, clk, rst_n, wr_en && (reg_index == REG_BINARY_MODE), cfg_reg.binary_mode == $past(pwdata[0]), "binary_mode write lost")
    `RTCTS_ASSERT_NEXT(a_h24_write, clk, rst_n, wr_en && (reg_index == REG_HOUR_24_MODE), cfg_reg.hour_24_mode == $past(pwdata[0]), "hour_24_mode write lost")
    `RTCTS_ASSERT_NEXT(a_cfg_hold, clk, rst_n, !wr_en, $stable(cfg_reg), "config changed without a write")

endmodule

@@ design/rtc_time_to_seconds_uptime.sv @@
// Top level: RTC snapshot to seconds since base, with elapsed time since boot.
//
// Each input item is one snapshot of the six raw RTC registers; each gives
// exactly one result item. The datapath is a 12-stage pipeline that takes
// one item per clock while the output side does not stall; bubbles close up
// under backpressure, so an item is still taken while a finished result
// waits, as long as some stage is empty. Stages: field decode, day count and
// time-of-day sum, day-to-seconds multiply, total, elapsed against the boot
// reference (op=1 stores the new reference here, after the elapsed value of
// the same item is formed), then three constant-reciprocal divide steps that
// split the elapsed seconds into days, hours, minutes and seconds.
`include "rtc_time_to_seconds_uptime_defines.svh"

module rtc_time_to_seconds_uptime (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtcts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rtcts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rtcts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year (8 each)
    input  logic [rtcts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic [0:0]                         s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hour_out, minute_out, second_out, day_out, month_out, year_out (8 each),
    // total_seconds (32), elapsed_days (16), elapsed_hours (5),
    // elapsed_minutes (6), elapsed_secs (6), zero fill (7)
    output logic [rtcts_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rtcts_pkg::*;

    localparam int unsigned ST_DECODE  = 0;
    localparam int unsigned ST_DAYS    = 1;
    localparam int unsigned ST_DPROD   = 2;
    localparam int unsigned ST_TOTAL   = 3;
    localparam int unsigned ST_ELAPSED = 4;
    localparam int unsigned ST_QDAY    = 5;
    localparam int unsigned ST_DSUB    = 6;
    localparam int unsigned ST_REMDAY  = 7;
    localparam int unsigned ST_QHOUR   = 8;
    localparam int unsigned ST_REMHOUR = 9;
    localparam int unsigned ST_QMIN    = 10;
    localparam int unsigned ST_SECS    = 11;
    localparam int unsigned NUM_STAGES = 12;
    localparam int unsigned LAST       = NUM_STAGES - 1;

    typedef logic [16:0] year_days_t [256];
    typedef logic [8:0]  month_days_t [12];

    typedef struct packed {
        logic        op;
        logic [7:0]  hr;
        logic [7:0]  mn;
        logic [7:0]  sc;
        logic [7:0]  dy;
        logic [7:0]  mo;
        logic [7:0]  yr;
        logic [3:0]  mon_c;
        logic [17:0] days;
        logic [19:0] hms;
        logic [31:0] dprod;
        logic [31:0] total;
        logic [31:0] elapsed;
        logic [15:0] qd;
        logic [31:0] dsub;
        logic [16:0] rem_d;
        logic [4:0]  qh;
        logic [11:0] rem_h;
        logic [5:0]  qm;
        logic [5:0]  secs;
    } pipe_t;

    function automatic logic is_leap(input int unsigned y);
        is_leap = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    // Days from BASE_YEAR-01-01 to the first day of each year offset.
    function automatic year_days_t build_year_days();
        year_days_t  t;
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < 256; i++)
        begin
            t[i] = 17'(acc);
            acc  = acc + (is_leap(BASE_YEAR + i) ? 366 : 365);
        end
        return t;
    endfunction

    function automatic logic [255:0] build_leap_map();
        logic [255:0] m;
        for (int unsigned i = 0; i < 256; i++)
        begin
            m[i] = is_leap(BASE_YEAR + i);
        end
        return m;
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        from_bcd = 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
    endfunction

    localparam year_days_t   YEAR_DAYS = build_year_days();
    localparam logic [255:0] LEAP_MAP  = build_leap_map();
    localparam month_days_t  MONTH_BEFORE = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    cfg_t cfg;

    pipe_t                  stage_reg  [NUM_STAGES];
    pipe_t                  stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  adv;
    logic [31:0]            boot_reg;
    logic [31:0]            boot_next;
    logic                   boot_load;

    logic [7:0]  raw_hour;
    logic [7:0]  hr_dec;
    logic [7:0]  hr_12;
    logic [7:0]  mon_dec;
    logic [3:0]  month_idx;
    logic        leap_add;
    logic [50:0] qd_prod;
    logic [37:0] qh_prod;
    logic [26:0] qm_prod;
    pipe_t       decode_next;
    pipe_t       out_stage;
    logic        split_ok;
    logic        rem_day_ok;

    rtcts_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int k = int'(LAST) - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[ST_DECODE];

    // Field decode into the first stage
    always_comb
    begin
        raw_hour = s_axis_tdata[23:16];
        hr_dec   = cfg.binary_mode ? raw_hour : from_bcd({1'b0, raw_hour[6:0]});
        hr_12    = {1'b0, hr_dec[6:0]};
        if (hr_12 == 8'd12)
        begin
            hr_12 = '0;
        end
        if (raw_hour[7])
        begin
            hr_12 = hr_12 + 8'd12;
        end

        decode_next    = '0;
        decode_next.op = s_axis_tuser[0];
        decode_next.hr = cfg.hour_24_mode ? hr_dec : hr_12;
        if (cfg.binary_mode)
        begin
            decode_next.sc = s_axis_tdata[7:0];
            decode_next.mn = s_axis_tdata[15:8];
            decode_next.dy = s_axis_tdata[31:24];
            mon_dec        = s_axis_tdata[39:32];
            decode_next.yr = s_axis_tdata[47:40];
        end
        else
        begin
            decode_next.sc = from_bcd(s_axis_tdata[7:0]);
            decode_next.mn = from_bcd(s_axis_tdata[15:8]);
            decode_next.dy = from_bcd(s_axis_tdata[31:24]);
            mon_dec        = from_bcd(s_axis_tdata[39:32]);
            decode_next.yr = from_bcd(s_axis_tdata[47:40]);
        end
        decode_next.mo = mon_dec;
        // Clamp the month used for the day count to 1..12
        if (mon_dec == 8'd0)
        begin
            decode_next.mon_c = 4'd1;
        end
        else if (mon_dec > 8'd12)
        begin
            decode_next.mon_c = 4'd12;
        end
        else
        begin
            decode_next.mon_c = mon_dec[3:0];
        end
    end

    // Later stages: carry the item forward and fill in one result each
    always_comb
    begin
        stage_next[ST_DECODE] = decode_next;
        for (int unsigned k = 1; k < NUM_STAGES; k++)
        begin
            stage_next[k] = stage_reg[k-1];
        end

        // Day count may reach -1 for day zero; it wraps through the multiply.
        month_idx = stage_reg[ST_DAYS-1].mon_c - 4'd1;
        leap_add  = LEAP_MAP[stage_reg[ST_DAYS-1].yr] && (stage_reg[ST_DAYS-1].mon_c > 4'd2);
        stage_next[ST_DAYS].days = 18'(YEAR_DAYS[stage_reg[ST_DAYS-1].yr])
                                 + 18'(MONTH_BEFORE[month_idx])
                                 + 18'(leap_add)
                                 + 18'(stage_reg[ST_DAYS-1].dy)
                                 - 18'd1;
        stage_next[ST_DAYS].hms  = 20'(stage_reg[ST_DAYS-1].hr) * 20'(SECS_PER_HOUR)
                                 + 20'(stage_reg[ST_DAYS-1].mn) * 20'(SECS_PER_MIN)
                                 + 20'(stage_reg[ST_DAYS-1].sc);

        stage_next[ST_DPROD].dprod =
            {{14{stage_reg[ST_DPROD-1].days[17]}}, stage_reg[ST_DPROD-1].days}
            * 32'(SECS_PER_DAY);

        stage_next[ST_TOTAL].total = stage_reg[ST_TOTAL-1].dprod
                                   + 32'(stage_reg[ST_TOTAL-1].hms);

        stage_next[ST_ELAPSED].elapsed = stage_reg[ST_ELAPSED-1].total - boot_reg;

        qd_prod = 51'(stage_reg[ST_QDAY-1].elapsed[31:DAY_PRE_SHIFT]) * 51'(DAY_RECIP);
        stage_next[ST_QDAY].qd = qd_prod[50:DAY_RECIP_SHIFT];

        stage_next[ST_DSUB].dsub = 32'(stage_reg[ST_DSUB-1].qd) * 32'(SECS_PER_DAY);

        stage_next[ST_REMDAY].rem_d =
            17'(stage_reg[ST_REMDAY-1].elapsed - stage_reg[ST_REMDAY-1].dsub);

        qh_prod = 38'(stage_reg[ST_QHOUR-1].rem_d) * 38'(HOUR_RECIP);
        stage_next[ST_QHOUR].qh = qh_prod[36:HOUR_RECIP_SHIFT];

        stage_next[ST_REMHOUR].rem_h =
            12'(stage_reg[ST_REMHOUR-1].rem_d
                - 17'(stage_reg[ST_REMHOUR-1].qh) * 17'(SECS_PER_HOUR));

        qm_prod = 27'(stage_reg[ST_QMIN-1].rem_h) * 27'(MIN_RECIP);
        stage_next[ST_QMIN].qm = qm_prod[25:MIN_RECIP_SHIFT];

        stage_next[ST_SECS].secs =
            6'(stage_reg[ST_SECS-1].rem_h
               - 12'(stage_reg[ST_SECS-1].qm) * 12'(SECS_PER_MIN));
    end

    // Store the new reference as an op=1 item enters the elapsed stage
    assign boot_load = adv[ST_ELAPSED] && valid_reg[ST_ELAPSED-1]
                       && stage_reg[ST_ELAPSED-1].op;
    assign boot_next = boot_load ? stage_reg[ST_ELAPSED-1].total : boot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            boot_reg  <= '0;
        end
        else
        begin
            boot_reg <= boot_next;
            if (adv[ST_DECODE])
            begin
                valid_reg[ST_DECODE] <= s_axis_tvalid;
            end
            for (int unsigned k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int unsigned k = 0; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_stage     = stage_reg[LAST];
    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {
        7'b0,
        out_stage.secs,
        out_stage.qm,
        out_stage.qh,
        out_stage.qd,
        out_stage.total,
        out_stage.yr,
        out_stage.mo,
        out_stage.dy,
        out_stage.sc,
        out_stage.mn,
        out_stage.hr
    };

    assign split_ok   = (out_stage.secs < 6'd60) && (out_stage.qm < 6'd60)
                        && (out_stage.qh < 5'd24);
    assign rem_day_ok = stage_reg[ST_REMDAY].rem_d < 17'(SECS_PER_DAY);

    `RTCTS_ASSERT_NEXT(a_boot_hold, clk, rst_n, !boot_load, $stable(boot_reg), "boot ref moved")
    `RTCTS_ASSERT_IMPLY(a_split_range, clk, rst_n, m_axis_tvalid, split_ok, "split out of range")
    `RTCTS_ASSERT_IMPLY(a_rem_day, clk, rst_n, valid_reg[ST_REMDAY], rem_day_ok, "bad remainder")
    `RTCTS_ASSERT_IMPLY(a_drain_ready, clk, rst_n, !valid_reg[LAST], s_axis_tready, "stuck input")

endmodule
